// File: rtl/ststem_pkg.sv
// Package for the Spanish token stopword stemmer.
// Holds sizes, config register indexes, cmd/status types, character classing and the constant tables.
// No dependencies.
package ststem_pkg;

  localparam int MaxWord  = 32;
  localparam int ResLimit = 32;
  localparam int LenW     = $clog2(MaxWord + 1);
  localparam int IdxW     = $clog2(MaxWord);
  localparam int CfgIdxW  = 2;
  localparam int StopCnt  = 32;
  localparam int SufCnt   = 11;

  localparam logic [CfgIdxW-1:0] CfgMinStem  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStopEn   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStemEn   = 2'd2;

  // Command from the controller to the datapath
  typedef struct packed {
    logic store_char;  // write the classified char at word_length
    logic set_ovf;     // note a dropped char
    logic clr_word;    // reset length and overflow
    logic ld_stop;     // capture stopword result
    logic ld_stem;     // capture emit length
    logic start_emit;  // load emit index with zero
    logic adv_emit;    // advance emit index
    logic rd_char;     // read word buffer at emit index, or the next one when it advances
  } ststem_cmd_t;

  typedef struct packed {
    logic             is_stop;
    logic [LenW-1:0]  emit_len;
    logic [LenW-1:0]  emit_idx;
    logic             ovf;
  } ststem_sts_t;

  // Lowercased char, or zero for a separator
  function automatic logic [7:0] classify(input logic [15:0] u);
    logic [7:0] c;
    c = 8'd0;
    if (u[15:8] == 8'd0) begin
      if (u[7:0] >= 8'h41 && u[7:0] <= 8'h5A) c = u[7:0] + 8'd32;
      else if ((u[7:0] >= 8'h61 && u[7:0] <= 8'h7A) ||
               (u[7:0] >= 8'h30 && u[7:0] <= 8'h39)) c = u[7:0];
      else begin
        case (u[7:0])
          8'hC1, 8'hC9, 8'hCD, 8'hD3, 8'hDA, 8'hD1: c = u[7:0] + 8'h20;
          8'hE1, 8'hE9, 8'hED, 8'hF3, 8'hFA, 8'hF1: c = u[7:0];
          default: c = 8'd0;
        endcase
      end
    end
    return c;
  endfunction

  // Stopword table: four chars, zero padded, plus length
  function automatic logic [31:0] stop_word(input logic [4:0] i);
    logic [31:0] w;
    case (i)
      5'd0:  w = {"el", 16'd0};
      5'd1:  w = {"la", 16'd0};
      5'd2:  w = {"los", 8'd0};
      5'd3:  w = {"las", 8'd0};
      5'd4:  w = {"un", 16'd0};
      5'd5:  w = {"una", 8'd0};
      5'd6:  w = "unos";
      5'd7:  w = "unas";
      5'd8:  w = {"de", 16'd0};
      5'd9:  w = {"del", 8'd0};
      5'd10: w = {"al", 16'd0};
      5'd11: w = {"a", 24'd0};
      5'd12: w = {"en", 16'd0};
      5'd13: w = {"por", 8'd0};
      5'd14: w = "para";
      5'd15: w = {"con", 8'd0};
      5'd16: w = {"sin", 8'd0};
      5'd17: w = {"y", 24'd0};
      5'd18: w = {"o", 24'd0};
      5'd19: w = "pero";
      5'd20: w = {"que", 8'd0};
      5'd21: w = "como";
      5'd22: w = {"si", 16'd0};
      5'd23: w = {"no", 16'd0};
      5'd24: w = {"lo", 16'd0};
      5'd25: w = {"tu", 16'd0};
      5'd26: w = {"su", 16'd0};
      5'd27: w = {"mi", 16'd0};
      5'd28: w = {"es", 16'd0};
      5'd29: w = {"son", 8'd0};
      5'd30: w = {"ser", 8'd0};
      default: w = {"hay", 8'd0};
    endcase
    return w;
  endfunction

  function automatic logic [2:0] stop_len(input logic [31:0] w);
    logic [2:0] n;
    n = 3'd4;
    if (w[7:0] == 8'd0) n = 3'd3;
    if (w[15:8] == 8'd0) n = 3'd2;
    if (w[23:16] == 8'd0) n = 3'd1;
    return n;
  endfunction

  // Suffix table, first char in the top byte
  function automatic logic [39:0] suf_word(input logic [3:0] i);
    logic [39:0] w;
    case (i)
      4'd0:  w = "mente";
      4'd1:  w = {"ci", 8'hF3, "n", 8'd0};
      4'd2:  w = {"si", 8'hF3, "n", 8'd0};
      4'd3:  w = {"ando", 8'd0};
      4'd4:  w = "iendo";
      4'd5:  w = {"ado", 16'd0};
      4'd6:  w = {"ido", 16'd0};
      4'd7:  w = {"os", 24'd0};
      4'd8:  w = {"as", 24'd0};
      4'd9:  w = {"es", 24'd0};
      default: w = {"s", 32'd0};
    endcase
    return w;
  endfunction

  function automatic logic [2:0] suf_len(input logic [3:0] i);
    logic [2:0] n;
    case (i)
      4'd0, 4'd4: n = 3'd5;
      4'd1, 4'd2, 4'd3: n = 3'd4;
      4'd5, 4'd6: n = 3'd3;
      4'd7, 4'd8, 4'd9: n = 3'd2;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/ststem_datapath.sv
// Datapath: word buffer, length and overflow registers, stopword and suffix match.
// Depends on ststem_pkg.
module ststem_datapath import ststem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ststem_cmd_t      cmd_i,
  input  logic [7:0]       char_i,
  input  logic [4:0]       min_stem_i,
  input  logic             stem_en_i,
  output ststem_sts_t      sts_o,
  output logic [LenW-1:0]  word_len_o,
  output logic [7:0]       rd_char_o
);

  logic [7:0]      word_mem [MaxWord];
  logic [LenW-1:0] len_q, len_d;
  logic            ovf_q, ovf_d;
  logic            stop_q;
  logic [LenW-1:0] emit_len_q;
  logic [LenW-1:0] idx_q;
  logic [7:0]      rd_q;

  // Tail window: last five chars, and head window: first four
  logic [39:0] tail;
  logic [31:0] head;
  logic        stop_hit;
  logic [LenW-1:0] stem_len;
  logic [LenW-1:0] cut_len;
  logic [LenW-1:0] rd_addr;

  always_comb begin
    for (int k = 0; k < 5; k++) begin
      if (len_q > LenW'(k)) tail[8*k +: 8] = word_mem[IdxW'(len_q - LenW'(k + 1))];
      else tail[8*k +: 8] = 8'd0;
    end
    for (int k = 0; k < 4; k++) begin
      head[8*(3-k) +: 8] = word_mem[k];
    end
  end

  always_comb begin
    logic [31:0] w;
    logic [2:0]  n;
    logic        eq;
    stop_hit = 1'b0;
    for (int i = 0; i < StopCnt; i++) begin
      w = stop_word(5'(i));
      n = stop_len(w);
      eq = (len_q == LenW'(n));
      for (int k = 0; k < 4; k++) begin
        if (3'(k) < n && head[8*(3-k) +: 8] != w[8*(3-k) +: 8]) eq = 1'b0;
      end
      if (eq) stop_hit = 1'b1;
    end
  end

  always_comb begin
    logic [39:0] s;
    logic [2:0]  n;
    logic        eq;
    logic        found;
    stem_len = len_q;
    found = 1'b0;
    for (int i = 0; i < SufCnt; i++) begin
      s = suf_word(4'(i));
      n = suf_len(4'(i));
      eq = (len_q >= LenW'(n));
      // suffix char j from end: s byte (n-1-j) from top
      for (int j = 0; j < 5; j++) begin
        if (3'(j) < n && tail[8*j +: 8] != s[39 - 8*(32'(n) - 1 - j) -: 8]) eq = 1'b0;
      end
      if (!found && eq && (len_q - LenW'(n)) >= LenW'(min_stem_i)) begin
        found = 1'b1;
        stem_len = len_q - LenW'(n);
      end
    end
  end

  always_comb begin
    cut_len = stem_en_i ? stem_len : len_q;
    if (cut_len > LenW'(ResLimit)) cut_len = LenW'(ResLimit);
  end

  // Read ahead: when the index advances, fetch the next char
  assign rd_addr = cmd_i.adv_emit ? idx_q + LenW'(1) : idx_q;

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (cmd_i.clr_word) begin
      len_d = '0;
      ovf_d = 1'b0;
    end else begin
      if (cmd_i.store_char) len_d = len_q + LenW'(1);
      if (cmd_i.set_ovf) ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_char) word_mem[IdxW'(len_q)] <= char_i;
    if (cmd_i.rd_char) rd_q <= word_mem[IdxW'(rd_addr)];
    if (cmd_i.ld_stop) stop_q <= stop_hit;
    if (cmd_i.ld_stem) emit_len_q <= cut_len;
    if (cmd_i.start_emit) idx_q <= '0;
    else if (cmd_i.adv_emit) idx_q <= idx_q + LenW'(1);
  end

  assign sts_o.is_stop  = stop_q;
  assign sts_o.emit_len = emit_len_q;
  assign sts_o.emit_idx = idx_q;
  assign sts_o.ovf      = ovf_q;
  assign word_len_o     = len_q;
  assign rd_char_o      = rd_q;

endmodule

// File: rtl/ststem_ctrl.sv
// Controller: input acceptance, word finishing sequence and output register.
// Depends on ststem_pkg.
module ststem_ctrl import ststem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       char_i,
  input  logic             eot_i,
  input  logic             stop_en_i,
  input  ststem_sts_t      sts_i,
  input  logic [LenW-1:0]  word_len_i,
  input  logic [7:0]       rd_char_i,
  output ststem_cmd_t      cmd_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [7:0]       out_char_o,
  output logic             token_last_o,
  output logic             text_last_o,
  output logic             empty_marker_o,
  output logic             truncated_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_DECIDE, S_READ, S_EMPTY
  } state_e;

  state_e state_q;
  logic   eot_q;
  logic   sent_q;
  logic   ovf_q;
  logic   accept;
  logic   out_free;
  logic   load_out;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign load_out   = out_free && (state_q == S_READ || state_q == S_EMPTY);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && char_i != 8'd0) begin
          if (word_len_i < LenW'(MaxWord)) cmd_o.store_char = 1'b1;
          else cmd_o.set_ovf = 1'b1;
        end
      end
      S_EVAL: begin
        cmd_o.ld_stop    = 1'b1;
        cmd_o.ld_stem    = 1'b1;
        cmd_o.start_emit = 1'b1;
      end
      S_DECIDE: begin
        if (sts_i.emit_len != '0 && !(stop_en_i && sts_i.is_stop) && word_len_i != '0)
          cmd_o.rd_char = 1'b1;
        else if (!eot_q || sent_q) cmd_o.clr_word = 1'b1;
      end
      S_READ: begin
        if (out_free) begin
          cmd_o.adv_emit = 1'b1;
          if (sts_i.emit_idx + LenW'(1) < sts_i.emit_len) cmd_o.rd_char = 1'b1;
          else cmd_o.clr_word = 1'b1;
        end
      end
      S_EMPTY: begin
        if (out_free) cmd_o.clr_word = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      eot_q       <= 1'b0;
      sent_q      <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_o <= 1'b0;
      out_char_o  <= 8'd0;
      token_last_o <= 1'b0;
      text_last_o <= 1'b0;
      empty_marker_o <= 1'b0;
      truncated_o <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i && !load_out) out_valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            eot_q  <= eot_i;
            sent_q <= 1'b0;
            // overflow from this char is visible after the edge
            ovf_q  <= sts_i.ovf || cmd_o.set_ovf;
            if (char_i == 8'd0 || eot_i) state_q <= S_EVAL;
          end
        end
        S_EVAL: state_q <= S_DECIDE;
        S_DECIDE: begin
          if (cmd_o.rd_char) state_q <= S_READ;
          else if (eot_q) state_q <= S_EMPTY;
          else state_q <= S_IDLE;
        end
        S_READ: begin
          if (out_free) begin
            out_valid_o    <= 1'b1;
            out_char_o     <= rd_char_i;
            token_last_o   <= cmd_o.clr_word;
            text_last_o    <= cmd_o.clr_word && eot_q;
            empty_marker_o <= 1'b0;
            truncated_o    <= ovf_q;
            sent_q         <= 1'b1;
            if (cmd_o.clr_word) state_q <= S_IDLE;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            out_valid_o    <= 1'b1;
            out_char_o     <= 8'd0;
            token_last_o   <= 1'b0;
            text_last_o    <= 1'b1;
            empty_marker_o <= 1'b1;
            truncated_o    <= 1'b0;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ststem_cfg.sv
// Configuration registers written over the valid/ready port.
// Depends on ststem_pkg.
module ststem_cfg import ststem_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [4:0]         cfg_data_i,
  output logic [4:0]         min_stem_o,
  output logic               stop_en_o,
  output logic               stem_en_o
);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_stem_o <= 5'd3;
      stop_en_o  <= 1'b1;
      stem_en_o  <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgMinStem: min_stem_o <= cfg_data_i;
        CfgStopEn:  stop_en_o  <= cfg_data_i[0];
        CfgStemEn:  stem_en_o  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/spanish_token_stopword_stemmer.sv
// Top level of the Spanish token stopword stemmer.
// Depends on ststem_pkg, ststem_cfg, ststem_ctrl, ststem_datapath.
//
// Input channel: one UTF-16 code unit per transfer with an end-of-text flag.
// Letters are folded to lowercase Latin-1 and, with digits, collected into a 32-char buffer;
// any other unit ends the current word.
// Output channel: one transfer per emitted char, with token_last, text_last,
// truncated, and a single empty_marker item when the last word of a text emits no char.
// Config port: valid/ready, always ready; index 0 min stem length,
// 1 stopword enable, 2 stem enable. Other indexes are ignored.
// Kept letters are accepted back to back while idle. A word end then steps through
// the evaluate state (stopword and suffix match captured) and the decide state, and
// emits its chars one at a time through the single read port of the word buffer.
// While the block finishes a word it stalls the input. A stalled output
// holds its item and the block waits; nothing is lost.
// Reset clears the word length, overflow flag and config registers to
// 3 / 1 / 1; buffer contents are not cleared.
module spanish_token_stopword_stemmer import ststem_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_unit_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        token_last_o,
  output logic        text_last_o,
  output logic        empty_marker_o,
  output logic        truncated_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [4:0]  cfg_data_i
);

  ststem_cmd_t     cmd;
  ststem_sts_t     sts;
  logic [LenW-1:0] word_len;
  logic [7:0]      rd_char;
  logic [7:0]      ch;
  logic [4:0]      min_stem;
  logic            stop_en, stem_en;

  assign ch = classify(code_unit_i);

  ststem_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .min_stem_o(min_stem), .stop_en_o(stop_en), .stem_en_o(stem_en)
  );

  ststem_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .char_i(ch), .eot_i(end_of_text_i),
    .stop_en_i(stop_en), .sts_i(sts), .word_len_i(word_len), .rd_char_i(rd_char),
    .cmd_o(cmd), .out_valid_o, .out_stall_i, .out_char_o, .token_last_o,
    .text_last_o, .empty_marker_o, .truncated_o
  );

  ststem_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .char_i(ch), .min_stem_i(min_stem),
    .stem_en_i(stem_en), .sts_o(sts), .word_len_o(word_len), .rd_char_o(rd_char)
  );

endmodule

// File: rtl/ststem_checker.sv
// Port-level checker for the stemmer, bound to the top level.
// Depends on ststem_pkg.
module ststem_sva import ststem_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_char_o,
  input logic       token_last_o,
  input logic       text_last_o,
  input logic       empty_marker_o,
  input logic       truncated_o
);

  a_empty_is_text_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && empty_marker_o |-> text_last_o && !token_last_o && out_char_o == 8'd0)
    else $error("empty marker without text end");

  a_text_end_closes_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_last_o && !empty_marker_o |-> token_last_o)
    else $error("text end inside a token");

  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !empty_marker_o |-> out_char_o != 8'd0)
    else $error("null char emitted");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o))
    else $error("stalled output changed");

endmodule

bind spanish_token_stopword_stemmer ststem_sva u_checker (.*);
